// File: rtl/core/uvda_pkg.sv
// Shared types, constants and conversion table for the undervoltage duration alarm.
package uvda_pkg;

  localparam int TICKS_PER_SECOND_DEF = 20;
  localparam int SAMPLES_AVERAGED_DEF = 3;

  localparam int SAMPLE_W    = 8;
  localparam int VOLT_W      = 9;
  localparam int SECONDS_W   = 7;
  localparam int LEVEL_W     = 7;
  localparam int LED_W       = 8;
  localparam int SUM_W       = 10;
  localparam int AVG_SHIFT   = 18;
  localparam int AVG_RECIP_W = AVG_SHIFT + 1;

  localparam logic [VOLT_W-1:0]    THRESHOLD_RST = 9'd300;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = 7'd127;
  localparam logic [LEVEL_W-1:0]   LEVEL_STEP3   = 7'd120;
  localparam logic [LEVEL_W-1:0]   LEVEL_STEP2   = 7'd80;
  localparam logic [LEVEL_W-1:0]   LEVEL_STEP1   = 7'd40;
  localparam logic [SECONDS_W-1:0] SECONDS_MAX   = 7'd99;
  localparam logic [LED_W-1:0]     LED_ALL_OFF   = 8'hFF;
  localparam logic [LED_W-1:0]     LED_BLINK     = 8'h80;
  localparam logic [LED_W-1:0]     LED_L1_L3     = 8'h07;
  localparam logic [LED_W-1:0]     LED_L1_L2     = 8'h03;
  localparam logic [LED_W-1:0]     LED_L1        = 8'h01;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
    logic [SAMPLE_W-1:0] sample_third;
  } uvda_in_t;

  typedef struct packed {
    logic [LED_W-1:0]     led_pattern;
    logic [SECONDS_W-1:0] alarm_seconds;
    logic [VOLT_W-1:0]    voltage_centivolts;
    logic                 timing_active;
  } uvda_out_t;

  typedef logic [VOLT_W-1:0] volt_lut_t [256];

  // floor(avg * 500 / 255) for every 8-bit average
  function automatic volt_lut_t build_volt_lut();
    volt_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = VOLT_W'((i * 500) / 255);
    end
    return lut;
  endfunction

  localparam volt_lut_t VOLT_LUT = build_volt_lut();

endpackage

// File: rtl/core/uvda_volt.sv
// Sample averaging and conversion of the average to centivolts.
module uvda_volt #(
  parameter int SAMPLES_AVERAGED = uvda_pkg::SAMPLES_AVERAGED_DEF
) (
  input  uvda_pkg::uvda_in_t              samples,
  output logic [uvda_pkg::VOLT_W-1:0]     volts
);
  import uvda_pkg::*;

  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'(((1 << AVG_SHIFT) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);

  logic [SUM_W-1:0]               sum;
  logic [SUM_W+AVG_RECIP_W-1:0]   prod;
  logic [SUM_W:0]                 quot;
  logic [SAMPLE_W-1:0]            avg;

  always_comb begin
    sum = SUM_W'(samples.sample_first);
    if (SAMPLES_AVERAGED >= 2) begin
      sum = sum + SUM_W'(samples.sample_second);
    end
    if (SAMPLES_AVERAGED >= 3) begin
      sum = sum + SUM_W'(samples.sample_third);
    end
  end

  // divide by the sample count through a scaled reciprocal
  assign prod = (SUM_W+AVG_RECIP_W)'(sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);
  assign quot = prod[SUM_W+AVG_RECIP_W-1:AVG_SHIFT];
  assign avg  = (quot > (SUM_W+1)'(255)) ? 8'hFF : quot[SAMPLE_W-1:0];

  assign volts = VOLT_LUT[avg];

endmodule

// File: rtl/core/undervoltage_duration_alarm.sv
// Top level of the undervoltage duration alarm: input register, state update, result register.
//
//  channel  ports                         direction  transaction
//  in       in_valid, in_stall, in_data   input      one sample set or one 50 ms tick
//  out      out_valid, out_stall, out_data output    lights, seconds, voltage, timing flag
//  cfg      cfg_we, cfg_wdata             input      threshold write, no read-back
//
// One transaction per cycle sustained while out_stall is low; out_valid rises once an accepted
// transaction has passed the input register, then the result register, with the state update in between.
// Synchronous active-low reset: threshold 300, lights off, timing cleared.
// A stall on the output holds both registers; in_stall rises only when both are full.
module undervoltage_duration_alarm #(
  parameter int TICKS_PER_SECOND = uvda_pkg::TICKS_PER_SECOND_DEF,
  parameter int SAMPLES_AVERAGED = uvda_pkg::SAMPLES_AVERAGED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  uvda_pkg::uvda_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output uvda_pkg::uvda_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [uvda_pkg::VOLT_W-1:0]     cfg_wdata
);
  import uvda_pkg::*;

  localparam int PHASE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [PHASE_W:0] PHASE_WRAP = (PHASE_W+1)'(TICKS_PER_SECOND);

  logic                  in_valid_r;
  uvda_in_t              in_data_r;
  logic                  out_valid_r;
  uvda_out_t             out_data_r;
  logic [VOLT_W-1:0]     threshold_r;

  logic                  timing_r,  timing_nxt;
  logic [LEVEL_W-1:0]    level_r,   level_nxt;
  logic [PHASE_W-1:0]    phase_r,   phase_nxt;
  logic [SECONDS_W-1:0]  seconds_r, seconds_nxt;
  logic                  blink_r,   blink_nxt;
  logic [LED_W-1:0]      light_r,   light_nxt;
  logic [VOLT_W-1:0]     volt_r,    volt_nxt;

  logic                  out_load;
  logic                  in_load;
  logic [VOLT_W-1:0]     sample_volts;
  logic [PHASE_W:0]      phase_inc;
  logic                  sec_wrap;

  assign out_load = in_valid_r && (!out_valid_r || !out_stall);
  assign in_load  = !in_valid_r || out_load;
  assign in_stall = !in_load;

  uvda_volt #(
    .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
  ) u_volt (
    .samples(in_data_r),
    .volts  (sample_volts)
  );

  assign phase_inc = (PHASE_W+1)'(phase_r) + (PHASE_W+1)'(1);
  assign sec_wrap  = (phase_inc >= PHASE_WRAP);

  always_comb begin
    timing_nxt  = timing_r;
    level_nxt   = level_r;
    phase_nxt   = phase_r;
    seconds_nxt = seconds_r;
    blink_nxt   = blink_r;
    light_nxt   = light_r;
    volt_nxt    = volt_r;
    if (in_data_r.kind == KIND_SAMPLE) begin
      volt_nxt = sample_volts;
      if (sample_volts < threshold_r) begin
        timing_nxt = 1'b1;
      end else begin
        timing_nxt  = 1'b0;
        level_nxt   = '0;
        phase_nxt   = '0;
        seconds_nxt = '0;
        blink_nxt   = 1'b0;
        light_nxt   = LED_ALL_OFF;
      end
    end else if (timing_r) begin
      if (level_r < LEVEL_MAX) begin
        level_nxt = level_r + LEVEL_W'(1);
      end
      phase_nxt = sec_wrap ? '0 : phase_inc[PHASE_W-1:0];
      if (sec_wrap) begin
        if (seconds_r < SECONDS_MAX) begin
          seconds_nxt = seconds_r + SECONDS_W'(1);
        end
        if (blink_r) begin
          light_nxt = light_r ^ LED_BLINK;
        end
      end
      if (level_nxt > LEVEL_STEP3) begin
        light_nxt = light_nxt & ~LED_L1_L3;
        blink_nxt = 1'b1;
      end else if (level_nxt > LEVEL_STEP2) begin
        light_nxt = light_nxt & ~LED_L1_L2;
      end else if (level_nxt > LEVEL_STEP1) begin
        light_nxt = light_nxt & ~LED_L1;
      end else begin
        light_nxt = LED_ALL_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RST;
      timing_r    <= 1'b0;
      level_r     <= '0;
      phase_r     <= '0;
      seconds_r   <= '0;
      blink_r     <= 1'b0;
      light_r     <= LED_ALL_OFF;
      volt_r      <= '0;
    end else begin
      if (cfg_we) begin
        threshold_r <= cfg_wdata;
      end
      if (in_load) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        timing_r    <= timing_nxt;
        level_r     <= level_nxt;
        phase_r     <= phase_nxt;
        seconds_r   <= seconds_nxt;
        blink_r     <= blink_nxt;
        light_r     <= light_nxt;
        volt_r      <= volt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r.led_pattern        <= light_nxt;
      out_data_r.alarm_seconds      <= seconds_nxt;
      out_data_r.voltage_centivolts <= volt_nxt;
      out_data_r.timing_active      <= timing_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
